// File: hw/rtl/ctw_pkg.sv
package ctw_pkg;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REARM  = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic [2:0] CMD_NOP    = 3'd0;
  localparam logic [2:0] CMD_ADD    = 3'd1;
  localparam logic [2:0] CMD_REARM  = 3'd2;
  localparam logic [2:0] CMD_REMOVE = 3'd3;
  localparam logic [2:0] CMD_TICK   = 3'd4;

  localparam logic KIND_TIMEOUT = 1'b0;
  localparam logic KIND_DONE    = 1'b1;

  localparam int MAX_TIMEOUTS = 32;

  typedef struct packed {
    logic [2:0]         code;
    logic [4:0]         idx;
    logic signed [16:0] timeout;
    logic [31:0]        now;
  } ctw_cmd_t;

  typedef struct packed {
    logic     valid;
    ctw_cmd_t cmd;
  } ctw_q_t;

endpackage

// File: hw/rtl/connection_timer_wheel.sv
// Channel   Signals                                         Handshake
// request   op conn_index timeout_seconds now_seconds       req_valid / req_stall
// response  kind expired_index last                         rsp_valid / rsp_stall
//
// Add, rearm and remove pass through an execute and a done state; a tick walks
// n slots (at most WHEEL_SLOTS), with one read-then-update pass over the
// connection RAM per slot.
// Synchronous active-high reset clears the valid bits, slot pointer and time.
// A two-entry command queue keeps taking requests while the wheel walks until
// both entries are full; a stalled response holds the walk at the next timeout.
module connection_timer_wheel #(
  parameter int WHEEL_SLOTS = 32,
  parameter int MAX_CONNS   = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [1:0]         op,
  input  logic [4:0]         conn_index,
  input  logic signed [16:0] timeout_seconds,
  input  logic [31:0]        now_seconds,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic               kind,
  output logic [4:0]         expired_index,
  output logic               last
);
  import ctw_pkg::*;

  ctw_q_t q_head;
  logic   q_pop;

  ctw_front #(.MAX_CONNS(MAX_CONNS)) u_front (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .op              (op),
    .conn_index      (conn_index),
    .timeout_seconds (timeout_seconds),
    .now_seconds     (now_seconds),
    .q_head          (q_head),
    .q_pop           (q_pop)
  );

  ctw_back #(.WHEEL_SLOTS(WHEEL_SLOTS), .MAX_CONNS(MAX_CONNS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .kind          (kind),
    .expired_index (expired_index),
    .last          (last)
  );

endmodule

// File: hw/rtl/ctw_ram.sv
module ctw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/ctw_front.sv
module ctw_front #(
  parameter int MAX_CONNS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic [1:0]          op,
  input  logic [4:0]          conn_index,
  input  logic signed [16:0]  timeout_seconds,
  input  logic [31:0]         now_seconds,
  output ctw_pkg::ctw_q_t     q_head,
  input  logic                q_pop
);
  import ctw_pkg::*;

  ctw_cmd_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  ctw_cmd_t   cls;
  logic       push;
  logic       pop;

  always_comb begin
    cls.idx     = conn_index;
    cls.timeout = timeout_seconds;
    cls.now     = now_seconds;
    if (op == OP_TICK) begin
      cls.code = CMD_TICK;
    end else if ({2'b00, conn_index} >= 7'(MAX_CONNS)) begin
      cls.code = CMD_NOP;
    end else begin
      unique case (op)
        OP_ADD:   cls.code = CMD_ADD;
        OP_REARM: cls.code = CMD_REARM;
        default:  cls.code = CMD_REMOVE;
      endcase
    end
  end

  assign req_stall    = (count == 2'd2);
  assign push         = req_valid && !req_stall;
  assign pop          = q_pop && (count != 2'd0);
  assign q_head.valid = (count != 2'd0);
  assign q_head.cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cls;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// File: hw/rtl/ctw_back.sv
module ctw_back #(
  parameter int WHEEL_SLOTS = 32,
  parameter int MAX_CONNS   = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  ctw_pkg::ctw_q_t q_head,
  output logic            q_pop,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output logic            kind,
  output logic [4:0]      expired_index,
  output logic            last
);
  import ctw_pkg::*;

  localparam int AW  = MAX_CONNS > 1 ? $clog2(MAX_CONNS) : 1;
  localparam int SW  = $clog2(WHEEL_SLOTS);
  localparam int SLW = $clog2(WHEEL_SLOTS + 1);
  localparam int RW  = SLW + 32 + 17;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_PROC = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]           state;
  ctw_cmd_t             cmd;
  logic [SW-1:0]        cur;
  logic [31:0]          tnow;
  logic [MAX_CONNS-1:0] valid;
  logic [SW:0]          left;
  logic [AW-1:0]        scan;
  logic [5:0]           em_cnt;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [RW-1:0]        wdata;
  logic                 re;
  logic [RW-1:0]        rdata;

  logic [AW-1:0]        idx_a;
  logic [SLW-1:0]       rd_slot;
  logic [31:0]          rd_exp;
  logic signed [16:0]   rd_to;
  logic                 hit;
  logic                 expired;
  logic                 want_emit;
  logic                 out_free;
  logic                 advance;
  logic                 last_entry;
  logic [SW-1:0]        nr_span;
  logic [SW:0]          nr_sum;
  logic [SLW-1:0]       nr_slot;
  logic [SW:0]          rem;
  logic [31:0]          diff;
  logic [SW+1:0]        ahead_raw;
  logic [SW:0]          ahead;
  logic [SW+1:0]        run_sum;
  logic [SLW-1:0]       run_slot;
  logic [31:0]          tick_d;
  logic [SW:0]          tick_left;
  logic                 rearm_wr;

  ctw_ram #(.WIDTH(RW), .DEPTH(MAX_CONNS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (scan),
    .rdata (rdata)
  );

  always_comb begin
    idx_a   = AW'(cmd.idx);
    rd_slot = rdata[RW-1 -: SLW];
    rd_exp  = rdata[48:17];
    rd_to   = rdata[16:0];

    hit       = valid[scan] && (rd_slot == SLW'(cur));
    expired   = !rd_to[16] && (rd_exp <= tnow);
    want_emit = hit && expired && !em_cnt[5];
    out_free  = !rsp_valid || !rsp_stall;
    advance   = (state == S_PROC) && (!want_emit || out_free);
    last_entry = (scan == AW'(MAX_CONNS - 1));

    if ({1'b0, cmd.timeout} >= 18'(WHEEL_SLOTS - 1)) begin
      nr_span = SW'(WHEEL_SLOTS - 1);
    end else begin
      nr_span = cmd.timeout[SW-1:0];
    end
    nr_sum = {1'b0, cur} + {1'b0, nr_span};
    if (nr_sum >= (SW+1)'(WHEEL_SLOTS)) begin
      nr_sum = nr_sum - (SW+1)'(WHEEL_SLOTS);
    end
    nr_slot = cmd.timeout[16] ? SLW'(WHEEL_SLOTS) : SLW'(nr_sum[SW-1:0]);

    rem  = left - (SW+1)'(1);
    diff = rd_exp - tnow;
    if (diff >= 32'(WHEEL_SLOTS)) begin
      ahead_raw = (SW+2)'(WHEEL_SLOTS);
    end else begin
      ahead_raw = {1'b0, rem} + {1'b0, diff[SW:0]};
    end
    ahead = (ahead_raw >= (SW+2)'(WHEEL_SLOTS)) ? (SW+1)'(WHEEL_SLOTS) : ahead_raw[SW:0];
    run_sum = {2'b00, cur} + {1'b0, ahead};
    if (run_sum >= (SW+2)'(WHEEL_SLOTS)) begin
      run_sum = run_sum - (SW+2)'(WHEEL_SLOTS);
    end
    run_slot = rd_to[16] ? SLW'(WHEEL_SLOTS) : SLW'(run_sum[SW-1:0]);

    tick_d = cmd.now - tnow;
    if (cmd.now <= tnow) begin
      tick_left = '0;
    end else if (tick_d >= 32'(WHEEL_SLOTS)) begin
      tick_left = (SW+1)'(WHEEL_SLOTS);
    end else begin
      tick_left = tick_d[SW:0];
    end

    rearm_wr = (cmd.code == CMD_ADD) || ((cmd.code == CMD_REARM) && valid[idx_a]);

    re    = (state == S_RD);
    we    = 1'b0;
    waddr = idx_a;
    wdata = {nr_slot, tnow + {16'h0000, cmd.timeout[15:0]}, cmd.timeout};
    if (state == S_EXEC) begin
      we = rearm_wr;
    end else if (state == S_PROC) begin
      we    = hit && !expired;
      waddr = scan;
      wdata = {run_slot, rd_exp, rd_to};
    end

    q_pop = (state == S_IDLE) && q_head.valid;
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_head.valid) begin
      cmd <= q_head.cmd;
    end
    if (rst) begin
      state     <= S_IDLE;
      cur       <= '0;
      tnow      <= '0;
      valid     <= '0;
      left      <= '0;
      scan      <= '0;
      em_cnt    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_head.valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_DONE;
          case (cmd.code)
            CMD_ADD:    valid[idx_a] <= 1'b1;
            CMD_REMOVE: valid[idx_a] <= 1'b0;
            CMD_TICK: begin
              tnow   <= cmd.now;
              left   <= tick_left;
              scan   <= '0;
              em_cnt <= '0;
              if (tick_left != '0) begin
                state <= S_RD;
              end
            end
            default: ;
          endcase
        end
        S_RD: begin
          state <= S_PROC;
        end
        S_PROC: begin
          if (want_emit && out_free) begin
            rsp_valid     <= 1'b1;
            kind          <= KIND_TIMEOUT;
            expired_index <= 5'(scan);
            last          <= 1'b0;
            em_cnt        <= em_cnt + 6'd1;
          end
          if (advance) begin
            state <= S_RD;
            if (last_entry) begin
              scan <= '0;
              cur  <= (cur == SW'(WHEEL_SLOTS - 1)) ? '0 : cur + SW'(1);
              left <= rem;
              if (left == (SW+1)'(1)) begin
                state <= S_DONE;
              end
            end else begin
              scan <= scan + AW'(1);
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            rsp_valid     <= 1'b1;
            kind          <= KIND_DONE;
            expired_index <= 5'd0;
            last          <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/ctw_checker.sv
module ctw_checker (
  input logic       clk,
  input logic       rst,
  input logic       rsp_valid,
  input logic       rsp_stall,
  input logic       kind,
  input logic [4:0] expired_index,
  input logic       last
);
  import ctw_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(kind) && $stable(expired_index)
      && $stable(last))
    else $error("stalled response changed");

  a_timeout_not_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && kind == KIND_TIMEOUT |-> !last)
    else $error("timeout marked last");

  a_done_form: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && kind == KIND_DONE |-> last && expired_index == 5'd0)
    else $error("malformed done response");

endmodule

bind connection_timer_wheel ctw_checker u_ctw_checker (
  .clk           (clk),
  .rst           (rst),
  .rsp_valid     (rsp_valid),
  .rsp_stall     (rsp_stall),
  .kind          (kind),
  .expired_index (expired_index),
  .last          (last)
);

// File: tb/tb_connection_timer_wheel.sv
`timescale 1ns / 1ps

class wheel_scoreboard;
  localparam int SLOTS = 32;
  localparam int CONNS = 32;

  bit                 live[CONNS];
  int unsigned        slot_of[CONNS];
  logic [31:0]        expiry_of[CONNS];
  int                 timeout_of[CONNS];
  int unsigned        cur_slot;
  logic [31:0]        clock_now;
  logic [31:0]        last_tick;
  logic [6:0]         pending[$];
  int                 errors;

  function new();
    for (int i = 0; i < CONNS; i++) live[i] = 0;
    cur_slot = 0;
    clock_now = 0;
    last_tick = 0;
    errors = 0;
  endfunction

  function void queue_result(logic [6:0] v);
    pending = {pending, v};
  endfunction

  function void put_slot(int i, int t, bit running);
    int unsigned span;
    if (t < 0) begin
      slot_of[i] = SLOTS;
      return;
    end
    span = running ? SLOTS : SLOTS - 1;
    if (t < span) span = t;
    slot_of[i] = (cur_slot + span) % SLOTS;
  endfunction

  function void arm(int i, int t);
    timeout_of[i] = t;
    if (t >= 0) expiry_of[i] = clock_now + 32'(t);
    put_slot(i, t, 0);
  endfunction

  function void note_request(logic [1:0] op, logic [4:0] idx, logic signed [16:0] tmo,
                             logic [31:0] now);
    int t;
    int unsigned cnt;
    int n;
    longint ahead;
    t = tmo;
    n = 0;
    if (op == ctw_pkg::OP_TICK) begin
      cnt = 0;
      clock_now = now;
      if (now > last_tick) cnt = (now - last_tick) < SLOTS ? now - last_tick : SLOTS;
      while (cnt > 0) begin
        cnt--;
        for (int i = 0; i < CONNS; i++) begin
          if (!live[i] || slot_of[i] != cur_slot) continue;
          if (timeout_of[i] < 0) slot_of[i] = SLOTS;
          else if (expiry_of[i] <= now) begin
            if (n < 32) begin
              queue_result({ctw_pkg::KIND_TIMEOUT, 5'(i), 1'b0});
              n++;
            end
          end else begin
            ahead = longint'(cnt) + longint'(expiry_of[i] - now);
            if (ahead > SLOTS) ahead = SLOTS;
            put_slot(i, int'(ahead), 1);
          end
        end
        cur_slot = (cur_slot + 1) % SLOTS;
      end
      last_tick = now;
    end else if (op == ctw_pkg::OP_ADD) begin
      if (!live[idx]) begin
        live[idx] = 1;
        slot_of[idx] = SLOTS;
      end
      arm(idx, t);
    end else if (op == ctw_pkg::OP_REARM) begin
      if (live[idx]) arm(idx, t);
    end else begin
      live[idx] = 0;
    end
    queue_result({ctw_pkg::KIND_DONE, 5'd0, 1'b1});
  endfunction

  task automatic report(string what, logic [6:0] got, logic [6:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  task automatic check_result(logic k, logic [4:0] idx, logic lst);
    logic [6:0] want;
    if (pending.size() == 0) begin
      report("unexpected", {k, idx, lst}, 7'h0);
      return;
    end
    want = pending.pop_front();
    if (k != want[6]) report("kind", {k, idx, lst}, want);
    if (idx != want[5:1]) report("expired_index", {k, idx, lst}, want);
    if (lst != want[0]) report("last", {k, idx, lst}, want);
  endtask
endclass

module tb_connection_timer_wheel;
  logic               clk;
  logic               rst;
  logic               req_valid;
  logic               req_stall;
  logic [1:0]         op;
  logic [4:0]         conn_index;
  logic signed [16:0] timeout_seconds;
  logic [31:0]        now_seconds;
  logic               rsp_valid;
  logic               rsp_stall;
  logic               kind;
  logic [4:0]         expired_index;
  logic               last;

  wheel_scoreboard sb;
  int               hold_rsp;
  int               idle_cycles;
  logic [31:0]      tnow;
  bit               stim_done;

  connection_timer_wheel u_top (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 20000) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int gap;
    rsp_stall = 1;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (rsp_valid && !rsp_stall) sb.check_result(kind, expired_index, last);
      if (hold_rsp > 0) begin
        rsp_stall <= 1;
        repeat (hold_rsp) @(posedge clk);
        hold_rsp = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
        rsp_stall <= 1;
        repeat (gap) @(posedge clk);
        rsp_stall <= 0;
      end else rsp_stall <= 0;
    end
  end

  task automatic send(logic [1:0] o, logic [4:0] i, logic signed [16:0] t, logic [31:0] n);
    int gap;
    gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      req_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1;
    op <= o;
    conn_index <= i;
    timeout_seconds <= t;
    now_seconds <= n;
    do @(posedge clk); while (req_stall);
    sb.note_request(o, i, t, n);
  endtask

  task automatic drain();
    req_valid <= 0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic random_op();
    int r;
    logic signed [16:0] t;
    r = $urandom_range(0, 9);
    case ($urandom_range(0, 5))
      0: t = -17'sd1;
      1: t = 17'($urandom);
      2: t = 17'sd65535;
      default: t = 17'($urandom_range(0, 40));
    endcase
    if (r < 3) send(ctw_pkg::OP_ADD, 5'($urandom), t, 32'($urandom));
    else if (r < 5) send(ctw_pkg::OP_REARM, 5'($urandom), t, 32'($urandom));
    else if (r < 6) send(ctw_pkg::OP_REMOVE, 5'($urandom), t, 32'($urandom));
    else begin
      case ($urandom_range(0, 7))
        0: tnow = 32'($urandom);
        1: tnow = tnow - 32'($urandom_range(0, 5));
        2: tnow = tnow + 32'($urandom_range(30, 100));
        default: tnow = tnow + 32'($urandom_range(0, 4));
      endcase
      send(ctw_pkg::OP_TICK, 5'($urandom), 17'($urandom), tnow);
    end
  endtask

  initial begin
    sb = new();
    hold_rsp = 0;
    tnow = 0;
    rst = 1;
    req_valid = 0;
    op = 0;
    conn_index = 0;
    timeout_seconds = 0;
    now_seconds = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send(ctw_pkg::OP_ADD, 5'd0, 17'sd0, 32'd0);
    send(ctw_pkg::OP_ADD, 5'd31, 17'sd65535, 32'hFFFFFFFF);
    send(ctw_pkg::OP_ADD, 5'd5, -17'sd1, 32'd0);
    send(ctw_pkg::OP_ADD, 5'd6, -17'sd65536, 32'd0);
    send(ctw_pkg::OP_ADD, 5'd7, 17'sd3, 32'd0);
    send(ctw_pkg::OP_ADD, 5'd7, 17'sd2, 32'd0);
    send(ctw_pkg::OP_REARM, 5'd9, 17'sd4, 32'd0);
    send(ctw_pkg::OP_REMOVE, 5'd10, 17'sd0, 32'd0);
    send(ctw_pkg::OP_REARM, 5'd6, 17'sd40, 32'd0);
    send(ctw_pkg::OP_TICK, 5'd0, 17'sd0, 32'd1);
    send(ctw_pkg::OP_TICK, 5'd0, 17'sd0, 32'd3);
    send(ctw_pkg::OP_TICK, 5'd0, 17'sd0, 32'd2);
    send(ctw_pkg::OP_TICK, 5'd0, 17'sd0, 32'd10);
    send(ctw_pkg::OP_REMOVE, 5'd7, 17'sd0, 32'd0);
    for (int i = 0; i < 32; i++) send(ctw_pkg::OP_ADD, 5'(i), 17'sd1, 32'd0);
    send(ctw_pkg::OP_TICK, 5'd0, 17'sd0, 32'd100);
    send(ctw_pkg::OP_TICK, 5'd0, 17'sd0, 32'hFFFFFFFF);
    send(ctw_pkg::OP_ADD, 5'd3, 17'sd65535, 32'd0);
    send(ctw_pkg::OP_TICK, 5'd0, 17'sd0, 32'd0);
    tnow = 0;
    drain();
    hold_rsp = 400;
    for (int i = 0; i < 30; i++) random_op();
    drain();
    for (int i = 0; i < 330; i++) random_op();
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

// File: files.f
hw/rtl/ctw_pkg.sv
hw/rtl/ctw_ram.sv
hw/rtl/ctw_front.sv
hw/rtl/ctw_back.sv
hw/rtl/connection_timer_wheel.sv
hw/rtl/ctw_checker.sv
tb/tb_connection_timer_wheel.sv
